// ----- rtl/midst_pkg.sv -----
// shared types, codes and length rounding for the message id slot table
`timescale 1ns / 1ps
`default_nettype none

package midst_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int ID_W      = 32;
    localparam int HANDLE_W  = 8;
    localparam int SIZE_W    = 7;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

    localparam logic [HANDLE_W-1:0] NULL_HANDLE = '0;

    // can fd frame lengths, ascending
    localparam logic [SIZE_W-1:0] FD_LENGTHS [8] =
        '{7'd8, 7'd12, 7'd16, 7'd20, 7'd24, 7'd32, 7'd48, 7'd64};
    localparam logic [SIZE_W-1:0] FD_MAX = 7'd64;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     message_id;
        logic [HANDLE_W-1:0] buffer_handle;
        logic [SIZE_W-1:0]   payload_size;
    } msg_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [HANDLE_W-1:0] found_handle;
        logic [SIZE_W-1:0]   padded_length;
        logic [COUNT_W-1:0]  entry_count;
    } msg_out_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [HANDLE_W-1:0] handle;
        logic [SIZE_W-1:0]   size;
    } entry_t;

    typedef struct packed {
        logic cmp_en;
        logic update;
        logic append;
        logic shift;
    } cell_ctrl_t;

    // smallest frame length not below size, saturating at 64
    function automatic logic [SIZE_W-1:0] fd_round(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] len;
        len = FD_MAX;
        for (int k = 7; k >= 0; k--) begin
            if (size <= FD_LENGTHS[k]) begin
                len = FD_LENGTHS[k];
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/midst_cell.sv -----
// one table slot: entry storage, id compare and shift-down link
`timescale 1ns / 1ps
`default_nettype none

module midst_cell (
    input  wire logic                              clk,
    input  wire midst_pkg::cell_ctrl_t             ctrl,
    input  wire logic [midst_pkg::ID_W-1:0]        cmp_id,
    input  wire logic [midst_pkg::ID_W-1:0]        wr_id,
    input  wire logic [midst_pkg::HANDLE_W-1:0]    wr_handle,
    input  wire logic [midst_pkg::SIZE_W-1:0]      wr_size,
    input  wire logic                              in_use,
    input  wire logic                              is_tail,
    input  wire midst_pkg::entry_t                 next_entry,
    input  wire logic                              seen_in,
    output midst_pkg::entry_t                      entry,
    output logic                                   match,
    output logic                                   seen_out
);

    midst_pkg::entry_t entry_reg;
    midst_pkg::entry_t entry_next;
    logic              match_reg;
    logic              match_next;

    // hit at or below this slot
    assign seen_out = seen_in | match_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.shift && seen_out)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.update && match_reg)
        begin
            entry_next.handle = wr_handle;
            entry_next.size   = wr_size;
        end
        else if (ctrl.append && is_tail)
        begin
            entry_next.id     = wr_id;
            entry_next.handle = wr_handle;
            entry_next.size   = wr_size;
        end
        else
        begin
            // hold
            entry_next = entry_reg;
        end
    end

    assign match_next = ctrl.cmp_en ? (in_use && (entry_reg.id == cmp_id)) : match_reg;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ----- rtl/message_id_slot_table_core.sv -----
// top level of the message id slot table: cell chain, control and result register
`timescale 1ns / 1ps
`default_nettype none

// Packed table of up to CAPACITY entries mapping a 32-bit message id to a
// buffer handle and payload size, built as a row of slot cells. Add updates
// a matching entry or appends at the tail (null handle and full table are
// rejected), remove deletes the match and every later cell takes its upper
// neighbor's entry at once, lookup returns slot, handle and the payload
// size rounded up to the next CAN FD frame length. One transaction at a
// time: the accept edge launches the id compare in every cell at once, the
// resolve state after it resolves the hit and commits the table change and
// the result; it waits in the resolve state only while the previous result
// has not been taken. Entries are not cleared at reset; only slots below
// the entry count are ever compared or read.
module message_id_slot_table_core #(
    parameter int CAPACITY = midst_pkg::CAPACITY_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire midst_pkg::msg_in_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output midst_pkg::msg_out_t       out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                state_reg;
    logic                  out_valid_reg;
    midst_pkg::msg_out_t   out_data_reg;
    logic [CNT_W-1:0]      count_reg;
    midst_pkg::msg_in_t    req_reg;

    logic                  in_fire;
    logic                  commit;

    // cell chain wiring
    midst_pkg::entry_t     cell_entry [CAPACITY];
    logic [CAPACITY-1:0]   match_vec;
    logic [CAPACITY:0]     seen;
    midst_pkg::cell_ctrl_t ctrl;

    // hit resolution
    logic                           any_hit;
    logic [CNT_W-1:0]               hit_idx;
    logic [midst_pkg::HANDLE_W-1:0] hit_handle;
    logic [midst_pkg::SIZE_W-1:0]   hit_size;
    logic                           full;

    // action decode
    logic                           do_update;
    logic                           do_append;
    logic                           do_shift;
    logic [CNT_W-1:0]               count_next;
    midst_pkg::msg_out_t            result;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    // resolve cycle may only commit once the result register is free
    assign commit   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign seen[0] = 1'b0;

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            midst_pkg::entry_t nb_entry;

            if (k == CAPACITY - 1)
            begin : g_last
                // top slot has no upper neighbor; its contents go stale after a shift
                assign nb_entry = cell_entry[k];
            end
            else
            begin : g_mid
                assign nb_entry = cell_entry[k + 1];
            end

            midst_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .cmp_id     (in_data.message_id),
                .wr_id      (req_reg.message_id),
                .wr_handle  (req_reg.buffer_handle),
                .wr_size    (req_reg.payload_size),
                .in_use     (CNT_W'(k) < count_reg),
                .is_tail    (CNT_W'(k) == count_reg),
                .next_entry (nb_entry),
                .seen_in    (seen[k]),
                .entry      (cell_entry[k]),
                .match      (match_vec[k]),
                .seen_out   (seen[k + 1])
            );
        end
    endgenerate

    // ids in use are distinct, so at most one cell matches: or-reduce
    always_comb
    begin
        hit_idx    = '0;
        hit_handle = '0;
        hit_size   = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
            begin
                hit_idx    = hit_idx | CNT_W'(i);
                hit_handle = hit_handle | cell_entry[i].handle;
                hit_size   = hit_size | cell_entry[i].size;
            end
        end
    end

    // end of the seen chain: some cell matched
    assign any_hit = seen[CAPACITY];
    assign full    = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        do_update = 1'b0;
        do_append = 1'b0;
        do_shift  = 1'b0;
        count_next = count_reg;
        result.status        = midst_pkg::ST_OK;
        result.slot_index    = '0;
        result.found_handle  = '0;
        result.padded_length = '0;
        unique case (req_reg.action)
            midst_pkg::ACT_ADD:
            begin
                priority if (req_reg.buffer_handle == midst_pkg::NULL_HANDLE)
                begin
                    result.status = midst_pkg::ST_NULL;
                end
                else if (any_hit)
                begin
                    do_update = 1'b1;
                    result.slot_index = midst_pkg::SLOT_W'(hit_idx);
                end
                else if (full)
                begin
                    result.status = midst_pkg::ST_FULL;
                end
                else
                begin
                    do_append  = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    result.slot_index = midst_pkg::SLOT_W'(count_reg);
                end
            end
            midst_pkg::ACT_REMOVE:
            begin
                if (any_hit)
                begin
                    do_shift   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    result.slot_index = midst_pkg::SLOT_W'(hit_idx);
                end
                else
                begin
                    result.status = midst_pkg::ST_ABSENT;
                end
            end
            midst_pkg::ACT_LOOKUP:
            begin
                if (any_hit)
                begin
                    result.slot_index    = midst_pkg::SLOT_W'(hit_idx);
                    result.found_handle  = hit_handle;
                    result.padded_length = midst_pkg::fd_round(hit_size);
                end
                else
                begin
                    result.status = midst_pkg::ST_ABSENT;
                end
            end
            default:
            begin
                // unused action code: no change
            end
        endcase
        result.entry_count = midst_pkg::COUNT_W'(count_next);
    end

    assign ctrl.cmp_en = in_fire;
    assign ctrl.update = commit && do_update;
    assign ctrl.append = commit && do_append;
    assign ctrl.shift  = commit && do_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            count_reg     <= '0;
            req_reg       <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (out_valid_reg && out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                    if (in_fire)
                    begin
                        req_reg   <= in_data;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (commit)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= result;
                        count_reg     <= count_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $onehot0(match_vec))
        else $error("more than one slot matched the id");

    a_count_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("entry count changed outside a commit");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not enter resolve");
`endif

endmodule

`default_nettype wire
